// ===== sv/mtg_pkg.sv =====
// shared constants, state codes and command/status structs of the mersenne twister generator
// used by the controller, the datapath and the top level; depends on nothing
package mtg_pkg;

  localparam int unsigned STATE_DEPTH  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned ADDR_W       = $clog2(STATE_DEPTH);
  localparam int unsigned POS_W        = 10;

  localparam logic [WORD_W-1:0] TOP_BIT      = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam int unsigned       SEED_SHIFT   = 30;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_WR,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_TW_RD,
    ST_TW_FAR,
    ST_TW_WR,
    ST_DRAW_ISSUE,
    ST_DRAW_WAIT
  } mtg_state_e;

  // source of the first ram read address
  typedef enum logic [1:0] {
    RADDR_POS,
    RADDR_CUR,
    RADDR_FAR
  } mtg_raddr_e;

  typedef struct packed {
    logic       load_seed;  // capture seed, clear index and read position
    logic       seed_wr;    // write current seed word
    logic       seed_mul;   // multiply step, advance index
    logic       seed_add;   // add index to product
    logic       tw_clr;     // start a twist at word zero
    logic       tw_y;       // form the mixed word from the two reads
    logic       tw_wr;      // write twisted word, advance index
    logic       pos_clr;    // restart reading at word zero
    logic       draw_load;  // load output register, advance read position
    mtg_raddr_e raddr_sel;
  } mtg_cmd_t;

  typedef struct packed {
    logic pos_end;   // all words of the state have been read
    logic k_last;    // index is at the last word
    logic out_busy;  // output register holds a word that is not taken this cycle
  } mtg_status_t;

endpackage

// ===== sv/mtg_ram.sv =====
// generic single write, dual read ram with registered read data
// no package dependency
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/mtg_datapath.sv =====
// datapath of the mersenne twister generator: state ram, seeding multiplier, twist mixer,
// read position and output register; uses mtg_pkg and mtg_ram
module mtg_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mtg_pkg::mtg_cmd_t           cmd_i,
  output mtg_pkg::mtg_status_t        status_o,
  input  logic [mtg_pkg::WORD_W-1:0]  seed_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [mtg_pkg::WORD_W-1:0]  value_o
);
  import mtg_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic [WORD_W-1:0] prev_q, prev_d;
  logic [WORD_W-1:0] prod_q, prod_d;
  logic [WORD_W-1:0] y_q, y_d;
  logic [WORD_W-1:0] value_q, value_d;
  logic              out_valid_q, out_valid_d;

  logic [ADDR_W-1:0] next_addr;
  logic [ADDR_W:0]   far_sum;
  logic [ADDR_W-1:0] far_addr;
  logic [ADDR_W-1:0] raddr_a;
  logic [WORD_W-1:0] rdata_a, rdata_b;
  logic [WORD_W-1:0] twist_word;
  logic [WORD_W-1:0] mag;
  logic [WORD_W-1:0] seed_mix;
  logic              we;
  logic [WORD_W-1:0] wdata;
  logic              k_last;

  assign k_last    = (k_q == ADDR_W'(STATE_DEPTH - 1));
  assign next_addr = k_last ? '0 : k_q + ADDR_W'(1);
  assign far_sum   = {1'b0, k_q} + (ADDR_W + 1)'(SHIFT_OFFSET);
  // offset wraps at most once
  assign far_addr  = (far_sum >= (ADDR_W + 1)'(STATE_DEPTH))
                     ? ADDR_W'(far_sum - (ADDR_W + 1)'(STATE_DEPTH))
                     : far_sum[ADDR_W-1:0];

  always_comb begin
    unique case (cmd_i.raddr_sel)
      RADDR_POS: raddr_a = pos_q[ADDR_W-1:0];
      RADDR_CUR: raddr_a = k_q;
      RADDR_FAR: raddr_a = far_addr;
      default:   raddr_a = k_q;
    endcase
  end

  assign mag        = y_q[0] ? TWIST_MATRIX : '0;
  assign twist_word = rdata_a ^ (y_q >> 1) ^ mag;
  assign seed_mix   = prev_q ^ (prev_q >> SEED_SHIFT);

  assign we    = cmd_i.seed_wr | cmd_i.tw_wr;
  assign wdata = cmd_i.tw_wr ? twist_word : prev_q;

  mtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STATE_DEPTH)
  ) u_state_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (k_q),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(next_addr),
    .rdata_b_o(rdata_b)
  );

  always_comb begin
    pos_d       = pos_q;
    k_d         = k_q;
    prev_d      = prev_q;
    prod_d      = prod_q;
    y_d         = y_q;
    value_d     = value_q;
    out_valid_d = out_valid_q & out_stall_i;

    if (cmd_i.load_seed) begin
      prev_d = seed_i;
      k_d    = '0;
      pos_d  = '0;
    end
    if (cmd_i.seed_mul) begin
      prod_d = SEED_MULT * seed_mix;
      k_d    = k_q + ADDR_W'(1);
    end
    if (cmd_i.seed_add) begin
      prev_d = prod_q + WORD_W'(k_q);
    end
    if (cmd_i.tw_clr) begin
      k_d = '0;
    end
    if (cmd_i.tw_y) begin
      y_d = (rdata_a & TOP_BIT) | (rdata_b & LOW_BITS);
    end
    if (cmd_i.tw_wr && !k_last) begin
      k_d = k_q + ADDR_W'(1);
    end
    if (cmd_i.pos_clr) begin
      pos_d = '0;
    end
    if (cmd_i.draw_load) begin
      value_d     = rdata_a;
      out_valid_d = 1'b1;
      pos_d       = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    prod_q  <= prod_d;
    y_q     <= y_d;
    value_q <= value_d;
  end

  assign status_o.pos_end  = (pos_q == POS_W'(STATE_DEPTH));
  assign status_o.k_last   = k_last;
  assign status_o.out_busy = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(STATE_DEPTH))
    else $error("read position past end of state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.draw_load)
    else $error("waiting word overwritten");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.seed_wr && cmd_i.tw_wr))
    else $error("seed and twist write in the same cycle");

  a_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(value_q)))
    else $error("waiting word lost");

endmodule

// ===== sv/mtg_ctrl.sv =====
// controller of the mersenne twister generator: sequences seeding, twisting and draws
// uses mtg_pkg; drives the datapath through mtg_cmd_t and reads mtg_status_t
module mtg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 operation_i,
  output logic                 in_stall_o,
  input  mtg_pkg::mtg_status_t status_i,
  output mtg_pkg::mtg_cmd_t    cmd_o
);
  import mtg_pkg::*;

  mtg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.raddr_sel  = RADDR_POS;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OP_SEED) begin
            cmd_o.load_seed = 1'b1;
            state_d         = ST_SEED_WR;
          end else if (status_i.pos_end) begin
            cmd_o.tw_clr = 1'b1;
            state_d      = ST_TW_RD;
          end else begin
            state_d = ST_DRAW_WAIT;
          end
        end
      end
      ST_SEED_WR: begin
        cmd_o.seed_wr = 1'b1;
        state_d       = status_i.k_last ? ST_IDLE : ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        cmd_o.seed_mul = 1'b1;
        state_d        = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        cmd_o.seed_add = 1'b1;
        state_d        = ST_SEED_WR;
      end
      // read word k and its neighbor, then the far word
      ST_TW_RD: begin
        cmd_o.raddr_sel = RADDR_CUR;
        state_d         = ST_TW_FAR;
      end
      ST_TW_FAR: begin
        cmd_o.raddr_sel = RADDR_FAR;
        cmd_o.tw_y      = 1'b1;
        state_d         = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd_o.raddr_sel = RADDR_FAR;
        cmd_o.tw_wr     = 1'b1;
        if (status_i.k_last) begin
          cmd_o.pos_clr = 1'b1;
          state_d       = ST_DRAW_ISSUE;
        end else begin
          state_d = ST_TW_RD;
        end
      end
      ST_DRAW_ISSUE: begin
        state_d = ST_DRAW_WAIT;
      end
      ST_DRAW_WAIT: begin
        if (!status_i.out_busy) begin
          cmd_o.draw_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_draw_only_on_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.draw_load |-> (state_q == ST_DRAW_WAIT))
    else $error("word loaded outside a draw");

  a_twist_ends_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TW_WR && status_i.k_last) |=> (state_q == ST_DRAW_ISSUE))
    else $error("twist did not hand over to a draw");

endmodule

// ===== sv/mersenne_twister_generator.sv =====
// top level of the mersenne twister generator (untempered mt19937 state recurrence)
// uses mtg_pkg, mtg_ctrl and mtg_datapath
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------
//   in      | in_valid_i | in_stall_o  | operation_i, seed_i
//   out     | out_valid_o| out_stall_i | value_o
//
// a draw does a registered read of the state ram, then loads the output register
// a draw after all 624 words were read first twists the state word by word (read, far, write)
// a seed fills the ram word by word (write, multiply, add) and gives no word
// reset clears the read position, output valid and controller; the ram is garbage until seeded
// a stalled output word holds the next draw in its wait state; seeds are still taken when idle
module mersenne_twister_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [mtg_pkg::WORD_W-1:0]  seed_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mtg_pkg::WORD_W-1:0]  value_o
);
  import mtg_pkg::*;

  mtg_cmd_t    cmd;
  mtg_status_t status;

  mtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mtg_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .seed_i     (seed_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .value_o    (value_o)
  );

endmodule

// ===== test/mersenne_twister_generator_test.sv =====
// self-checking testbench for mersenne_twister_generator: draws after seeds are checked
// against an in-bench predictor of the untempered mt19937 recurrence; depends on mtg_pkg
module mersenne_twister_generator_test;
  import mtg_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned DRAW_TARGET = 950;
  localparam int unsigned MAX_WAIT    = 18;

  typedef struct {
    logic              op;
    logic [WORD_W-1:0] seed;
    int unsigned       gap;
    bit                hold;  // wait until every drawn word has come back
  } gen_req_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              operation_i = OP_DRAW;
  logic [WORD_W-1:0] seed_i      = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [WORD_W-1:0] value_o;

  gen_req_t          pending_q[$];
  logic [WORD_W-1:0] drawn_q[$];
  int unsigned       req_cnt;
  bit                in_calm;
  bit                out_calm;
  int unsigned       gap_cnt;
  int unsigned       stall_left;
  int unsigned       idle_cycles;
  int unsigned       err_cnt;

  // predictor copy of the generator state
  logic [WORD_W-1:0] mt_state [STATE_DEPTH];
  int unsigned       mt_pos;

  mersenne_twister_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned rand_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic mt_reseed(logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    mt_state[0] = seed;
    for (int k = 1; k < STATE_DEPTH; k++) begin
      prev = mt_state[k-1];
      mt_state[k] = SEED_MULT * (prev ^ (prev >> SEED_SHIFT)) + k;
    end
    mt_pos = 0;
  endtask

  // in place, so the last words see the already twisted low words
  task automatic mt_twist();
    logic [WORD_W-1:0] y;
    for (int k = 0; k < STATE_DEPTH; k++) begin
      y = (mt_state[k] & TOP_BIT) | (mt_state[(k + 1) % STATE_DEPTH] & LOW_BITS);
      mt_state[k] = mt_state[(k + SHIFT_OFFSET) % STATE_DEPTH] ^ (y >> 1) ^
                    (y[0] ? TWIST_MATRIX : '0);
    end
  endtask

  task automatic mt_draw();
    if (mt_pos >= STATE_DEPTH) begin
      mt_twist();
      mt_pos = 0;
    end
    drawn_q.push_back(mt_state[mt_pos]);
    mt_pos++;
  endtask

  task automatic add_req(logic op, logic [WORD_W-1:0] seed, bit hold);
    gen_req_t r;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    r.op   = op;
    r.seed = seed;
    r.gap  = rand_wait(in_calm);
    r.hold = hold;
    pending_q.push_back(r);
    req_cnt++;
  endtask

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    err_cnt++;
  endtask

  // stimulus: directed seeds and draws first, then seeded runs of random length
  initial begin
    int  n;
    bit  first;
    first = 1'b1;
    add_req(OP_SEED, '0, 1'b0);
    add_req(OP_DRAW, '0, 1'b0);
    add_req(OP_DRAW, '1, 1'b0);
    add_req(OP_DRAW, $urandom, 1'b0);
    add_req(OP_SEED, '1, 1'b0);
    add_req(OP_DRAW, '1, 1'b0);
    add_req(OP_DRAW, '0, 1'b0);
    add_req(OP_SEED, 32'h8000_0000, 1'b0);
    add_req(OP_DRAW, 32'h7FFF_FFFF, 1'b0);
    // back to back seeds, only the second one counts
    add_req(OP_SEED, 32'h7FFF_FFFF, 1'b0);
    add_req(OP_SEED, 32'h0000_0001, 1'b0);
    add_req(OP_DRAW, $urandom, 1'b0);
    add_req(OP_DRAW, $urandom, 1'b0);
    add_req(OP_SEED, 32'd5489, 1'b1);
    for (int i = 0; i < 4; i++) add_req(OP_DRAW, $urandom, 1'b0);
    add_req(OP_DRAW, $urandom, 1'b1);
    add_req(OP_DRAW, $urandom, 1'b0);
    while (req_cnt < DRAW_TARGET) begin
      add_req(OP_SEED, pick_seed(), $urandom_range(0, 5) == 0);
      // first run reads past the end of the state to force a twist
      n = first ? STATE_DEPTH + $urandom_range(1, 60) : $urandom_range(0, 40);
      first = 1'b0;
      for (int i = 0; i < n; i++) add_req(OP_DRAW, $urandom, $urandom_range(0, 40) == 0);
    end
    for (int i = 0; i < 3; i++) add_req(OP_DRAW, $urandom, 1'b0);
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= OP_DRAW;
      seed_i      <= '0;
      gap_cnt     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (operation_i == OP_SEED) mt_reseed(seed_i);
        else mt_draw();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && gap_cnt >= pending_q[0].gap &&
            (!pending_q[0].hold || drawn_q.size() == 0)) begin
          in_valid_i  <= 1'b1;
          operation_i <= pending_q[0].op;
          seed_i      <= pending_q[0].seed;
          gap_cnt     <= 0;
          pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (pending_q.size() > 0) gap_cnt <= gap_cnt + 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned s;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (drawn_q.size() == 0) begin
          report_mismatch("unexpected word", value_o, '0);
        end else if (value_o !== drawn_q[0]) begin
          report_mismatch("value", value_o, drawn_q[0]);
          void'(drawn_q.pop_front());
        end else begin
          void'(drawn_q.pop_front());
        end
        if ($urandom_range(0, 49) == 0) out_calm <= !out_calm;
        s = rand_wait(out_calm);
        out_stall_i <= (s != 0);
        stall_left  <= (s == 0) ? 0 : s - 1;
      end else begin
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left <= stall_left - 1;
      end
    end
  end

  // watchdog on cycles in which no request and no word is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[mersenne_twister_generator] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (pending_q.size() != 0 || in_valid_i || drawn_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (err_cnt == 0 && drawn_q.size() == 0) begin
      $display("[mersenne_twister_generator] OK");
    end else begin
      $display("[mersenne_twister_generator] ERROR");
    end
    $finish;
  end

endmodule
